/* hdl/flc_pkg.sv */
// types, codes and helpers shared by the tagged lookup cache
package flc_pkg;

  localparam int TAG_W = 64;

  typedef logic [TAG_W-1:0] tag_t;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_FILLED    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_CLEARED   = 3'd5,
    ST_REJECTED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] handle;
    logic [4:0]  slot;
    logic        evicted;
  } rsp_t;

  typedef struct packed {
    logic wr;
    logic inv;
    logic clr;
  } tag_op_t;

  function automatic tag_t make_tag(
    input logic [15:0] clen,
    input logic [7:0]  cf,
    input logic [7:0]  cl,
    input logic [15:0] nlen,
    input logic [7:0]  nf,
    input logic [7:0]  nl
  );
    return {clen, cf, cl, nlen, nf, nl};
  endfunction

  function automatic rsp_t plain_rsp(input status_t st);
    rsp_t r;
    r.status  = st;
    r.handle  = '0;
    r.slot    = '0;
    r.evicted = 1'b0;
    return r;
  endfunction

endpackage

/* hdl/flc_tag_store.sv */
// tag memory with per-entry valid bits, registered read
module flc_tag_store #(
  parameter int ENTRIES = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [$clog2(ENTRIES)-1:0]  rd_addr,
  output flc_pkg::tag_t               rd_tag,
  input  flc_pkg::tag_op_t            op,
  input  logic [$clog2(ENTRIES)-1:0]  op_addr,
  input  flc_pkg::tag_t               wr_tag,
  output logic                        op_occupied
);

  localparam int IDX_W = $clog2(ENTRIES);

  flc_pkg::tag_t mem [ENTRIES];
  flc_pkg::tag_t rd_raw;
  logic [ENTRIES-1:0] valid;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (op.wr) begin
      mem[op_addr] <= wr_tag;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= valid[rd_addr];
      if (op.clr) begin
        valid <= '0;
      end else if (op.wr) begin
        valid[op_addr] <= 1'b1;
      end else if (op.inv) begin
        valid[op_addr] <= 1'b0;
      end
    end
  end

  // an entry never written or removed reads as the empty tag
  assign rd_tag      = rd_vld ? rd_raw : '0;
  assign op_occupied = valid[op_addr[IDX_W-1:0]];

endmodule

/* hdl/flc_handle_ram.sv */
// handle memory, one write and one registered read port
module flc_handle_ram #(
  parameter int ENTRIES     = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(ENTRIES)-1:0]  waddr,
  input  logic [HANDLE_BITS-1:0]      wdata,
  input  logic [$clog2(ENTRIES)-1:0]  raddr,
  output logic [HANDLE_BITS-1:0]      rdata
);

  logic [HANDLE_BITS-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/flc_ctrl.sv */
// sequencer: tag scan, fifo fill, remove and clear
module flc_ctrl #(
  parameter int ENTRIES     = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_go,
  input  logic [1:0]                  kind,
  input  logic [15:0]                 class_length,
  input  logic [7:0]                  class_first_char,
  input  logic [7:0]                  class_last_char,
  input  logic [15:0]                 ns_length,
  input  logic [7:0]                  ns_first_char,
  input  logic [7:0]                  ns_last_char,
  input  logic                        resolved_found,
  input  logic [31:0]                 resolved_handle,
  output logic                        busy,
  output logic                        res_valid,
  output flc_pkg::rsp_t               res,
  input  logic                        res_take,
  output logic [$clog2(ENTRIES)-1:0]  rd_addr,
  input  flc_pkg::tag_t               rd_tag,
  input  logic [HANDLE_BITS-1:0]      rd_handle,
  output flc_pkg::tag_op_t            tag_op,
  output logic [$clog2(ENTRIES)-1:0]  op_addr,
  output flc_pkg::tag_t               wr_tag,
  input  logic                        op_occupied,
  output logic                        hnd_we,
  output logic [HANDLE_BITS-1:0]      hnd_wdata
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  flc_pkg::state_t state, state_next;
  flc_pkg::tag_t   tag_q, tag_q_next;
  logic [1:0]      kind_q, kind_q_next;
  logic            found_q, found_q_next;
  logic [31:0]     rhandle_q, rhandle_q_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [CNT_W-1:0] issued, issued_next;
  logic             pend, pend_next;
  logic [IDX_W-1:0] pend_slot, pend_slot_next;
  logic [CNT_W-1:0] fill_level, fill_level_next;
  logic [IDX_W-1:0] last_hit, last_hit_next;
  logic [IDX_W-1:0] last_written, last_written_next;
  flc_pkg::rsp_t    res_q, res_q_next;

  flc_pkg::tag_t    req_tag;
  logic [CNT_W:0]   wrap1, wrap2;
  logic [IDX_W-1:0] scan_next, fill_slot;
  logic [HANDLE_BITS-1:0] hnd_new;
  logic [63:0]      hnd_new_wide, hnd_rd_wide;
  logic             hit;

  assign req_tag = flc_pkg::make_tag(class_length, class_first_char, class_last_char,
                                     ns_length, ns_first_char, ns_last_char);

  // lookup walk steps modulo the fill level
  always_comb begin
    wrap1 = (CNT_W+1)'(ptr) + (CNT_W+1)'(1);
    if (wrap1 >= (CNT_W+1)'(fill_level)) begin
      wrap1 = wrap1 - (CNT_W+1)'(fill_level);
    end
    wrap2 = wrap1;
    if (wrap2 >= (CNT_W+1)'(fill_level)) begin
      wrap2 = wrap2 - (CNT_W+1)'(fill_level);
    end
    scan_next = (kind_q == flc_pkg::KIND_LOOKUP) ? IDX_W'(wrap2) : ptr + 1'b1;
  end

  assign fill_slot    = (last_written == IDX_W'(ENTRIES - 1)) ? '0 : last_written + 1'b1;
  assign hnd_new      = HANDLE_BITS'(rhandle_q);
  assign hnd_new_wide = 64'(hnd_new);
  assign hnd_rd_wide  = 64'(rd_handle);
  assign hit          = pend && (rd_tag == tag_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= flc_pkg::S_IDLE;
      pend         <= 1'b0;
      fill_level   <= '0;
      last_hit     <= '0;
      last_written <= IDX_W'(ENTRIES - 1);
    end else begin
      state        <= state_next;
      pend         <= pend_next;
      fill_level   <= fill_level_next;
      last_hit     <= last_hit_next;
      last_written <= last_written_next;
    end
  end

  always_ff @(posedge clk) begin
    tag_q     <= tag_q_next;
    kind_q    <= kind_q_next;
    found_q   <= found_q_next;
    rhandle_q <= rhandle_q_next;
    ptr       <= ptr_next;
    issued    <= issued_next;
    pend_slot <= pend_slot_next;
    res_q     <= res_q_next;
  end

  always_comb begin
    state_next        = state;
    tag_q_next        = tag_q;
    kind_q_next       = kind_q;
    found_q_next      = found_q;
    rhandle_q_next    = rhandle_q;
    ptr_next          = ptr;
    issued_next       = issued;
    pend_next         = pend;
    pend_slot_next    = pend_slot;
    fill_level_next   = fill_level;
    last_hit_next     = last_hit;
    last_written_next = last_written;
    res_q_next        = res_q;
    tag_op            = '0;
    rd_addr           = ptr;
    op_addr           = pend_slot;
    wr_tag            = tag_q;
    hnd_we            = 1'b0;
    hnd_wdata         = hnd_new;

    unique case (state)
      flc_pkg::S_IDLE: begin
        if (req_go) begin
          tag_q_next     = req_tag;
          kind_q_next    = kind;
          found_q_next   = resolved_found;
          rhandle_q_next = resolved_handle;
          issued_next    = '0;
          pend_next      = 1'b0;
          if (kind == flc_pkg::KIND_CLEAR) begin
            tag_op.clr        = 1'b1;
            fill_level_next   = '0;
            last_hit_next     = '0;
            last_written_next = IDX_W'(ENTRIES - 1);
            res_q_next        = flc_pkg::plain_rsp(flc_pkg::ST_CLEARED);
            state_next        = flc_pkg::S_DONE;
          end else if (kind == flc_pkg::KIND_LOOKUP || kind == flc_pkg::KIND_REMOVE) begin
            if (class_length == '0 || ns_length == '0) begin
              res_q_next = flc_pkg::plain_rsp(flc_pkg::ST_REJECTED);
              state_next = flc_pkg::S_DONE;
            end else begin
              if (kind == flc_pkg::KIND_REMOVE
                  || CNT_W'(last_hit) > fill_level) begin
                ptr_next = '0;
              end else begin
                ptr_next = last_hit;
              end
              state_next = flc_pkg::S_SCAN;
            end
          end else begin
            res_q_next = flc_pkg::plain_rsp(flc_pkg::ST_REJECTED);
            state_next = flc_pkg::S_DONE;
          end
        end
      end

      flc_pkg::S_SCAN: begin
        if (hit) begin
          pend_next = 1'b0;
          if (kind_q == flc_pkg::KIND_LOOKUP) begin
            last_hit_next      = pend_slot;
            res_q_next         = flc_pkg::plain_rsp(flc_pkg::ST_HIT);
            res_q_next.handle  = hnd_rd_wide[31:0];
          end else begin
            tag_op.inv = 1'b1;
            res_q_next = flc_pkg::plain_rsp(flc_pkg::ST_REMOVED);
          end
          res_q_next.slot = 5'(pend_slot);
          state_next      = flc_pkg::S_DONE;
        end else if (issued < fill_level) begin
          pend_next      = 1'b1;
          pend_slot_next = ptr;
          issued_next    = issued + 1'b1;
          ptr_next       = scan_next;
        end else begin
          pend_next = 1'b0;
          if (kind_q == flc_pkg::KIND_REMOVE) begin
            res_q_next = flc_pkg::plain_rsp(flc_pkg::ST_ABSENT);
            state_next = flc_pkg::S_DONE;
          end else if (!found_q) begin
            res_q_next = flc_pkg::plain_rsp(flc_pkg::ST_NOT_FOUND);
            state_next = flc_pkg::S_DONE;
          end else begin
            state_next = flc_pkg::S_FILL;
          end
        end
      end

      flc_pkg::S_FILL: begin
        op_addr   = fill_slot;
        tag_op.wr = 1'b1;
        hnd_we    = 1'b1;
        if (fill_level != CNT_W'(ENTRIES)) begin
          fill_level_next = fill_level + 1'b1;
        end
        last_written_next  = fill_slot;
        last_hit_next      = fill_slot;
        res_q_next         = flc_pkg::plain_rsp(flc_pkg::ST_FILLED);
        res_q_next.handle  = hnd_new_wide[31:0];
        res_q_next.slot    = 5'(fill_slot);
        res_q_next.evicted = op_occupied;
        state_next         = flc_pkg::S_DONE;
      end

      flc_pkg::S_DONE: begin
        if (res_take) begin
          state_next = flc_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = flc_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = (state != flc_pkg::S_IDLE);
  assign res_valid = (state == flc_pkg::S_DONE);
  assign res       = res_q;

endmodule

/* hdl/fifo_tagged_lookup_cache.sv */
// top level of the fully associative tagged lookup cache
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------
//   request | req_valid | req_stall | kind, class_*, ns_*, resolved_found/handle
//   result  | rsp_valid | rsp_stall | status, handle, slot, evicted
//
// one item at a time; clear and rejected items skip the tag walk, lookup and remove
// walk the filled entries, and a fill writes one entry after the walk; the walk over
// the tag memory reads one entry per cycle
// reset empties the store at once through per-entry valid bits
// the result register lets the next item in while a result waits on rsp_stall
module fifo_tagged_lookup_cache #(
  parameter int ENTRIES     = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] class_length,
  input  logic [7:0]  class_first_char,
  input  logic [7:0]  class_last_char,
  input  logic [15:0] ns_length,
  input  logic [7:0]  ns_first_char,
  input  logic [7:0]  ns_last_char,
  input  logic        resolved_found,
  input  logic [31:0] resolved_handle,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  status,
  output logic [31:0] handle,
  output logic [4:0]  slot,
  output logic        evicted
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic                   busy;
  logic                   res_valid;
  logic                   res_take;
  flc_pkg::rsp_t          res;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       op_addr;
  flc_pkg::tag_t          rd_tag;
  flc_pkg::tag_t          wr_tag;
  flc_pkg::tag_op_t       tag_op;
  logic                   op_occupied;
  logic                   hnd_we;
  logic [HANDLE_BITS-1:0] hnd_wdata;
  logic [HANDLE_BITS-1:0] rd_handle;

  assign req_stall = busy;
  assign res_take  = res_valid && (!rsp_valid || !rsp_stall);

  flc_ctrl #(
    .ENTRIES     (ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .req_go           (req_valid && !req_stall),
    .kind             (kind),
    .class_length     (class_length),
    .class_first_char (class_first_char),
    .class_last_char  (class_last_char),
    .ns_length        (ns_length),
    .ns_first_char    (ns_first_char),
    .ns_last_char     (ns_last_char),
    .resolved_found   (resolved_found),
    .resolved_handle  (resolved_handle),
    .busy             (busy),
    .res_valid        (res_valid),
    .res              (res),
    .res_take         (res_take),
    .rd_addr          (rd_addr),
    .rd_tag           (rd_tag),
    .rd_handle        (rd_handle),
    .tag_op           (tag_op),
    .op_addr          (op_addr),
    .wr_tag           (wr_tag),
    .op_occupied      (op_occupied),
    .hnd_we           (hnd_we),
    .hnd_wdata        (hnd_wdata)
  );

  flc_tag_store #(
    .ENTRIES (ENTRIES)
  ) u_tags (
    .clk         (clk),
    .rst         (rst),
    .rd_addr     (rd_addr),
    .rd_tag      (rd_tag),
    .op          (tag_op),
    .op_addr     (op_addr),
    .wr_tag      (wr_tag),
    .op_occupied (op_occupied)
  );

  flc_handle_ram #(
    .ENTRIES     (ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_handles (
    .clk   (clk),
    .we    (hnd_we),
    .waddr (op_addr),
    .wdata (hnd_wdata),
    .raddr (rd_addr),
    .rdata (rd_handle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status  <= res.status;
      handle  <= res.handle;
      slot    <= res.slot;
      evicted <= res.evicted;
    end
  end

endmodule

/* hdl/flc_checker.sv */
// port-level checks for the tagged lookup cache, bound to the top level
module flc_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [2:0]  status,
  input logic [31:0] handle,
  input logic [4:0]  slot,
  input logic        evicted
);

  // a held result item keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(handle)
      && $stable(slot) && $stable(evicted))
    else $error("stalled result item changed");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while an item is in flight");

  // only a fill can report an eviction
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && evicted |-> status == flc_pkg::ST_FILLED)
    else $error("eviction flagged outside a fill");

  // answers without an entry carry no handle and no slot
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == flc_pkg::ST_NOT_FOUND || status == flc_pkg::ST_ABSENT
      || status == flc_pkg::ST_CLEARED || status == flc_pkg::ST_REJECTED)
      |-> handle == '0 && slot == '0)
    else $error("entry fields set on an entry-less answer");

endmodule

bind fifo_tagged_lookup_cache flc_checker u_flc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .status    (status),
  .handle    (handle),
  .slot      (slot),
  .evicted   (evicted)
);
